>>> design/spectrometer_word_channel_integrator_unit_assert.svh
// Assertion macros used by the integrator unit.
`ifndef SPECTROMETER_WORD_CHANNEL_INTEGRATOR_UNIT_ASSERT_SVH
`define SPECTROMETER_WORD_CHANNEL_INTEGRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SWCI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integrator assertion failed");

// Next-cycle implication, checked outside reset.
`define SWCI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integrator assertion failed");

`endif

>>> design/swci_pkg.sv
package swci_pkg;
    localparam int unsigned STORE_DEPTH = 512;
    localparam int unsigned STORE_AW    = 9;
    localparam int unsigned SUM_W       = 64;
    localparam int unsigned AMP_W       = 48;
    localparam int unsigned PROD_W      = 56;
    localparam logic [6:0]  EXP_ZERO    = 7'd109;
    localparam logic [AMP_W-1:0] Q48_MAX = {AMP_W{1'b1}};
    localparam logic [0:0]  REG_SCALE   = 1'b0;
    localparam logic [0:0]  REG_LENGTH  = 1'b1;
    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [AMP_W-1:0] t_amp;
endpackage

>>> design/swci_ram.sv
module swci_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/spectrometer_word_channel_integrator_unit.sv
// Flow: an accepted word passes through the multiply, shift and add states, then a bit-serial
// modulo step that tests whether a channel average is due that time point, and a bit-serial
// divide that forms the average when it is; the word then waits in the write-back state until
// the output register is free. No new word is accepted before the current one is written back.
// Reset: synchronous and active low; a pass over the whole sum store then clears the channel sums,
// during which no word is accepted.
`include "spectrometer_word_channel_integrator_unit_assert.svh"
module spectrometer_word_channel_integrator_unit
    import swci_pkg::*;
#(
    parameter int unsigned CHANNELS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_raw_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [8:0]  o_channel,
    output logic [47:0] o_amplitude,
    output logic [31:0] o_time_point,
    output logic        o_average_valid,
    output logic [47:0] o_average
);
    localparam int unsigned CW = $clog2(CHANNELS);
    localparam logic [CW-1:0] CH_LAST = CW'(CHANNELS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_MOD   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_WB    = 3'd7;

    logic [2:0]          r_state;
    logic [STORE_AW-1:0] r_clr;
    logic [31:0]         r_scale;
    logic [15:0]         r_len;
    logic [CW-1:0]       r_ch;
    logic [31:0]         r_pc;
    logic [31:0]         r_word;
    logic [PROD_W-1:0]   r_prod;
    logic [6:0]          r_exp;
    t_sum                r_sum;
    t_amp                r_amp;
    logic [63:0]         r_quo;
    logic [15:0]         r_rem;
    logic [6:0]          r_cnt;
    logic                r_avg_valid;
    t_amp                r_avg;
    logic                r_out_valid;
    logic [8:0]          r_o_channel;
    t_amp                r_o_amp;
    logic [31:0]         r_o_tp;
    logic                r_o_avg_valid;
    t_amp                r_o_avg;

    logic [15:0]         len_eff;
    logic [STORE_AW-1:0] slot;
    logic [CW+8:0]       ch_ext;
    logic                accept;
    logic                wb_go;
    logic                cfg_wr;
    t_sum                rdata;
    logic                mem_we;
    logic [STORE_AW-1:0] mem_waddr;
    t_sum                mem_wdata;
    t_amp                n_amp;
    logic [74:0]         lwide;
    logic [PROD_W-1:0]   rval;
    logic [6:0]          rsh;
    logic [4:0]          lsh;
    logic [64:0]         sum_add;
    t_sum                n_sum;
    logic [16:0]         rem_sh;
    logic [17:0]         diff;

    assign len_eff = (r_len == 16'd0) ? 16'd1 : r_len;
    assign ch_ext  = {9'd0, r_ch};
    assign slot    = ch_ext[8:0];
    assign accept  = i_in_valid && !o_in_stall;
    assign wb_go   = (r_state == S_WB) && (!r_out_valid || !i_out_stall);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_LENGTH) ? {16'd0, r_len} : r_scale;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        lsh   = 5'(r_exp - EXP_ZERO);
        rsh   = EXP_ZERO - r_exp;
        lwide = {19'd0, r_prod} << lsh;
        rval  = r_prod >> rsh[5:0];
        if (r_exp >= EXP_ZERO) begin
            n_amp = (|lwide[74:48]) ? Q48_MAX : lwide[47:0];
        end else if (rsh >= 7'd64) begin
            n_amp = '0;
        end else begin
            n_amp = (|rval[55:48]) ? Q48_MAX : rval[47:0];
        end
    end

    assign sum_add = {1'b0, r_sum} + {17'd0, r_amp};
    assign n_sum   = sum_add[64] ? {SUM_W{1'b1}} : sum_add[63:0];
    assign rem_sh  = {r_rem, r_quo[63]};
    assign diff    = {1'b0, rem_sh} - {2'd0, len_eff};

    assign mem_we    = (r_state == S_CLEAR) || wb_go;
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : slot;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : r_sum;

    swci_ram #(
        .WIDTH(SUM_W),
        .DEPTH(STORE_DEPTH)
    ) u_sums (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(slot),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_scale     <= 32'd16015631;
            r_len       <= 16'd1;
            r_ch        <= '0;
            r_pc        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_SCALE) begin
                    r_scale <= pwdata;
                end else begin
                    r_len <= pwdata[15:0];
                end
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == STORE_AW'(STORE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_word  <= i_raw_word;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'({32'd0, r_word[23:0]} * {24'd0, r_scale});
                    r_exp   <= r_word[30:24];
                    r_sum   <= rdata;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    r_amp   <= n_amp;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum   <= n_sum;
                    r_quo   <= {r_pc + 32'd1, 32'd0};
                    r_rem   <= '0;
                    r_cnt   <= 7'd32;
                    r_state <= S_MOD;
                end
                S_MOD, S_DIV: begin
                    if (r_cnt != 7'd0) begin
                        r_cnt <= r_cnt - 7'd1;
                        if (!diff[17]) begin
                            r_rem <= diff[15:0];
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[15:0];
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                    end else if (r_state == S_MOD) begin
                        if (r_rem == 16'd0) begin
                            r_quo   <= r_sum;
                            r_rem   <= '0;
                            r_cnt   <= 7'd64;
                            r_state <= S_DIV;
                        end else begin
                            r_avg_valid <= 1'b0;
                            r_avg       <= '0;
                            r_state     <= S_WB;
                        end
                    end else begin
                        r_avg_valid <= 1'b1;
                        r_avg       <= (|r_quo[63:48]) ? Q48_MAX : r_quo[47:0];
                        r_sum       <= '0;
                        r_state     <= S_WB;
                    end
                end
                S_WB: begin
                    if (wb_go) begin
                        r_out_valid   <= 1'b1;
                        r_o_channel   <= slot;
                        r_o_amp       <= r_amp;
                        r_o_tp        <= r_pc;
                        r_o_avg_valid <= r_avg_valid;
                        r_o_avg       <= r_avg;
                        if (r_ch == CH_LAST) begin
                            r_ch <= '0;
                            r_pc <= r_pc + 32'd1;
                        end else begin
                            r_ch <= r_ch + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel       = r_o_channel;
    assign o_amplitude     = r_o_amp;
    assign o_time_point    = r_o_tp;
    assign o_average_valid = r_o_avg_valid;
    assign o_average       = r_o_avg;

    `SWCI_ASSERT_IMP(a_clear_blocks_input, i_clk, i_rst_n, r_state == S_CLEAR, o_in_stall)
    `SWCI_ASSERT_IMP(a_write_only_at_end, i_clk, i_rst_n, mem_we,
        r_state == S_CLEAR || r_state == S_WB)
    `SWCI_ASSERT_NEXT(a_load_gives_word, i_clk, i_rst_n, wb_go, o_out_valid)
    `SWCI_ASSERT_IMP(a_count_bounded, i_clk, i_rst_n, 1'b1, r_cnt <= 7'd64)
endmodule

>>> dv/tb_spectrometer_word_channel_integrator_unit.sv
`timescale 1ns / 100ps
module tb_spectrometer_word_channel_integrator_unit;
    import swci_pkg::*;

    typedef struct packed {
        logic [8:0]  channel;
        t_amp        amplitude;
        logic [31:0] time_point;
        logic        average_valid;
        t_amp        average;
    } t_power_word;

    typedef struct {
        logic [31:0] raw;
        logic        known;
        t_power_word want;
    } t_dir_row;

    typedef struct {
        logic [31:0] scale;
        logic [15:0] length;
        int          words;
        int          send_idle;
        int          recv_idle;
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_raw_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [8:0]  o_channel;
    logic [47:0] o_amplitude;
    logic [31:0] o_time_point;
    logic        o_average_valid;
    logic [47:0] o_average;

    spectrometer_word_channel_integrator_unit u_dut (.*);

    always #5 i_clk = ~i_clk;

    logic [31:0] gain;
    logic [15:0] span;
    logic [8:0]  chan_idx;
    logic [31:0] spectrum_idx;
    t_sum        acc_mem [STORE_DEPTH];

    t_power_word pending_words[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    function automatic t_amp power_of(logic [31:0] raw);
        logic [63:0] prod;
        int          sh;
        prod = {40'd0, raw[23:0]} * {32'd0, gain};
        sh = int'(raw[30:24]) - int'(EXP_ZERO);
        if (sh >= 0) begin
            if (prod > ({16'd0, Q48_MAX} >> sh)) return Q48_MAX;
            return t_amp'(prod << sh);
        end
        if (-sh >= 64) return '0;
        prod = prod >> (-sh);
        return (prod > {16'd0, Q48_MAX}) ? Q48_MAX : t_amp'(prod);
    endfunction

    function automatic t_power_word integrate(logic [31:0] raw);
        t_power_word r;
        t_sum        sum;
        t_sum        avg;
        logic [31:0] len;
        logic [31:0] nxt;
        len = (span == 0) ? 32'd1 : {16'd0, span};
        r.channel = chan_idx;
        r.amplitude = power_of(raw);
        r.time_point = spectrum_idx;
        sum = acc_mem[chan_idx];
        sum = (sum > ({SUM_W{1'b1}} - {16'd0, r.amplitude})) ? {SUM_W{1'b1}}
                                                             : sum + r.amplitude;
        nxt = spectrum_idx + 32'd1;
        r.average_valid = ((nxt % len) == 0);
        r.average = '0;
        if (r.average_valid) begin
            avg = sum / {32'd0, len};
            r.average = (avg > {16'd0, Q48_MAX}) ? Q48_MAX : t_amp'(avg);
            sum = '0;
        end
        acc_mem[chan_idx] = sum;
        if (chan_idx == 9'(STORE_DEPTH - 1)) begin
            chan_idx = '0;
            spectrum_idx = spectrum_idx + 1;
        end else begin
            chan_idx = chan_idx + 1;
        end
        return r;
    endfunction

    task automatic reg_write(logic [0:0] idx, logic [31:0] value);
        logic [31:0] want_rd;
        want_rd = (idx == REG_SCALE) ? value : {16'd0, value[15:0]};
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_SCALE) gain = value;
        else span = value[15:0];
        @(negedge i_clk);
        if (prdata !== want_rd || pready !== 1'b1) begin
            mismatches++;
            if (mismatches <= 10)
                $display("readback: expected %h, got %h (ready %b)", want_rd, prdata, pready);
        end
        @(posedge i_clk);
    endtask

    task automatic send_word(logic [31:0] raw, logic known, t_power_word want);
        t_power_word pred;
        logic        taken;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_word <= raw;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        pred = integrate(raw);
        pending_words = {pending_words, (known ? want : pred)};
    endtask

    task automatic drain;
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_word;
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(3) != 0) w[30:24] = 7'($urandom_range(85, 127));
        return w;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(negedge i_clk) begin
        t_power_word got;
        t_power_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_channel, o_amplitude, o_time_point, o_average_valid, o_average};
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %p", got);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_dir_row    dir_rows[$];
        t_phase      phases[$];
        t_power_word none;
        none = '0;
        gain = 32'd16015631;
        span = 16'd1;
        chan_idx = '0;
        spectrum_idx = '0;
        foreach (acc_mem[i]) acc_mem[i] = '0;

        dir_rows = '{
            '{32'h0000_0000, 1'b1, '{9'd0, 48'd0, 32'd0, 1'b1, 48'd0}},
            '{32'h7FFF_FFFF, 1'b1, '{9'd1, Q48_MAX, 32'd0, 1'b1, Q48_MAX}},
            '{32'h00FF_FFFF, 1'b1, '{9'd2, 48'd0, 32'd0, 1'b1, 48'd0}},
            '{32'hFFFF_FFFF, 1'b1, '{9'd3, Q48_MAX, 32'd0, 1'b1, Q48_MAX}},
            '{32'h6D00_0001, 1'b0, none},
            '{32'h6D80_0000, 1'b0, none},
            '{32'h6C00_0001, 1'b0, none},
            '{32'h6DFF_FFFF, 1'b0, none},
            '{32'h4D00_0001, 1'b0, none},
            '{32'h2DFF_FFFF, 1'b0, none},
            '{32'h2EFF_FFFF, 1'b0, none},
            '{32'h7E00_0001, 1'b0, none},
            '{32'h7F00_0001, 1'b0, none},
            '{32'h7000_0FFF, 1'b0, none},
            '{32'h8000_0000, 1'b0, none},
            '{32'hAA55_AA55, 1'b0, none},
            '{32'h55AA_55AA, 1'b0, none}
        };
        phases = '{
            '{32'hFFFF_FFFF, 16'd1, 200, 37, 88},
            '{32'd0, 16'd0, 40, 37, 88},
            '{32'd16015631, 16'd2, 240, 88, 37},
            '{32'd1, 16'hFFFF, 120, 0, 0},
            '{32'h00C0_FFEE, 16'd2, 150, 0, 0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 88;
        foreach (dir_rows[i]) send_word(dir_rows[i].raw, dir_rows[i].known, dir_rows[i].want);
        drain();

        foreach (phases[p]) begin
            reg_write(REG_SCALE, phases[p].scale);
            reg_write(REG_LENGTH, {16'd0, phases[p].length});
            send_idle_pct = phases[p].send_idle;
            recv_idle_pct = phases[p].recv_idle;
            for (int n = 0; n < phases[p].words; n++) begin
                if (p == 0 && n == 100) begin
                    @(posedge i_clk);
                    i_in_valid <= 1'b0;
                    while (pending_words.size() != 0) @(posedge i_clk);
                end
                send_word(random_word(), 1'b0, none);
            end
            drain();
        end

        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> spectrometer_word_channel_integrator_unit.f
+incdir+design
design/swci_pkg.sv
design/swci_ram.sv
design/spectrometer_word_channel_integrator_unit.sv
dv/tb_spectrometer_word_channel_integrator_unit.sv
